// File: hdl/sae_pkg.sv
// Shared types and codes for the shifting array engine.
`default_nettype none

package sae_pkg;

  localparam int WORD_W = 32;

  typedef logic signed [WORD_W-1:0] word_t;

  // command codes
  localparam logic [2:0] CMD_APPEND    = 3'd0;
  localparam logic [2:0] CMD_INSERT    = 3'd1;
  localparam logic [2:0] CMD_SET       = 3'd2;
  localparam logic [2:0] CMD_READ      = 3'd3;
  localparam logic [2:0] CMD_REMOVE    = 3'd4;
  localparam logic [2:0] CMD_REM_RANGE = 3'd5;
  localparam logic [2:0] CMD_REM_LAST  = 3'd6;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  // cell operations
  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_LOAD = 2'd1;
  localparam logic [1:0] OP_UP   = 2'd2;
  localparam logic [1:0] OP_DOWN = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic       at;     // this cell is the target position
    logic       above;  // this cell lies above the target position
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: hdl/sae_cell.sv
// One storage cell of the shifting chain.
`default_nettype none

module sae_cell (
  input  wire                 clk,
  input  sae_pkg::cell_ctrl_t ctrl,
  input  sae_pkg::word_t      load_value,
  input  sae_pkg::word_t      left,
  input  sae_pkg::word_t      right,
  output sae_pkg::word_t      data
);
  import sae_pkg::*;

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LOAD: begin
        if (ctrl.at) data <= load_value;
      end
      OP_UP: begin
        if (ctrl.at) begin
          data <= load_value;
        end else if (ctrl.above) begin
          data <= left;
        end
      end
      OP_DOWN: begin
        if (ctrl.at || ctrl.above) data <= right;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/shifting_array_engine_top.sv
// Top level: command decode, fill count, result register and the cell chain.
//
//  channel | dir | width | contents
//  s_*     | in  | 48    | command[2:0] index[8:3] end_index[14:9] value[46:15]
//  m_*     | out | 48    | read_value[31:0] count[38:32] status[40:39]
//
// Remove range shifts the chain down once for each removed entry, since the chain
// moves entries down by one position per cycle.
// The result is registered and shows in the cycle after acceptance; a waiting result
// holds off the next command until the cycle it is taken, as does a range shift.
// rst clears the fill count and control; entries beyond the count are don't-care.
`default_nettype none

module shifting_array_engine_top #(
  parameter int CAPACITY = 64
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [47:0] s_tdata,   // command[2:0], index[8:3], end_index[14:9], value[46:15]
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [47:0] m_tdata    // read_value[31:0], count[38:32], status[40:39]
);
  import sae_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int TW    = (CNT_W > 6) ? CNT_W : 6;

  // input fields
  logic [2:0] command;
  logic [5:0] index;
  logic [5:0] end_index;
  word_t      value;

  assign command   = s_tdata[2:0];
  assign index     = s_tdata[8:3];
  assign end_index = s_tdata[14:9];
  assign value     = s_tdata[46:15];

  // control registers
  logic [CNT_W-1:0] fill_cnt;
  logic             busy;
  logic [TW-1:0]    rem_shifts;
  logic [TW-1:0]    busy_tgt;
  logic             out_valid;
  word_t            out_rd;
  logic [6:0]       out_cnt;
  logic [1:0]       out_st;

  logic accept;
  assign s_tready = !busy && (!out_valid || m_tready);
  assign accept   = s_tvalid && s_tready;

  // decode
  logic [TW-1:0]    ix, ex, cntx, len_m1, cmd_tgt, tgt;
  logic [CNT_W-1:0] cnt_next;
  logic [1:0]       st, op_cmd, op;
  logic             full, empty, rd_ok, go_busy;

  assign ix     = TW'(index);
  assign ex     = TW'(end_index);
  assign cntx   = TW'(fill_cnt);
  assign len_m1 = ex - ix;
  assign full   = (fill_cnt == CNT_W'(CAPACITY));
  assign empty  = (fill_cnt == '0);

  always_comb begin
    op_cmd   = OP_HOLD;
    cmd_tgt  = ix;
    st       = ST_OK;
    cnt_next = fill_cnt;
    rd_ok    = 1'b0;
    go_busy  = 1'b0;
    case (command)
      CMD_APPEND: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          op_cmd   = OP_LOAD;
          cmd_tgt  = cntx;
          cnt_next = fill_cnt + CNT_W'(1);
        end
      end
      CMD_INSERT: begin
        if (full) begin
          st = ST_FULL;
        end else if (ix > cntx) begin
          st = ST_RANGE;
        end else begin
          op_cmd   = OP_UP;
          cnt_next = fill_cnt + CNT_W'(1);
        end
      end
      CMD_SET: begin
        if (ix >= cntx) begin
          st = ST_RANGE;
        end else begin
          op_cmd = OP_LOAD;
        end
      end
      CMD_READ: begin
        if (ix >= cntx) begin
          st = ST_RANGE;
        end else begin
          rd_ok = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (empty) begin
          st = ST_EMPTY;
        end else if (ix >= cntx) begin
          st = ST_RANGE;
        end else begin
          op_cmd   = OP_DOWN;
          cnt_next = fill_cnt - CNT_W'(1);
        end
      end
      CMD_REM_RANGE: begin
        if (empty) begin
          st = ST_EMPTY;
        end else if (ix > ex || ex >= cntx) begin
          st = ST_RANGE;
        end else begin
          op_cmd   = OP_DOWN;
          cnt_next = fill_cnt - CNT_W'(len_m1) - CNT_W'(1);
          go_busy  = (len_m1 != '0);
        end
      end
      CMD_REM_LAST: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          cnt_next = fill_cnt - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // range removal keeps shifting down at the same position
  assign op  = busy ? OP_DOWN : (accept ? op_cmd : OP_HOLD);
  assign tgt = busy ? busy_tgt : cmd_tgt;

  // cell chain
  cell_ctrl_t cell_ctrl [CAPACITY];
  word_t      cell_data [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    // op, at, above
    assign cell_ctrl[i] = {op, (tgt == TW'(i)), (tgt < TW'(i))};

    if (i == 0) begin : g_first
      sae_cell u_cell (
        .clk        (clk),
        .ctrl       (cell_ctrl[i]),
        .load_value (value),
        .left       (value),
        .right      (cell_data[i+1]),
        .data       (cell_data[i])
      );
    end else if (i == CAPACITY - 1) begin : g_last
      sae_cell u_cell (
        .clk        (clk),
        .ctrl       (cell_ctrl[i]),
        .load_value (value),
        .left       (cell_data[i-1]),
        .right      (cell_data[i]),
        .data       (cell_data[i])
      );
    end else begin : g_mid
      sae_cell u_cell (
        .clk        (clk),
        .ctrl       (cell_ctrl[i]),
        .load_value (value),
        .left       (cell_data[i-1]),
        .right      (cell_data[i+1]),
        .data       (cell_data[i])
      );
    end
  end

  // read port: AND-OR over the one-hot target flags
  word_t rd_sel;
  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (cell_ctrl[i].at) rd_sel = rd_sel | cell_data[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_cnt   <= '0;
      busy       <= 1'b0;
      rem_shifts <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      if (busy) begin
        rem_shifts <= rem_shifts - TW'(1);
        if (rem_shifts == TW'(1)) busy <= 1'b0;
      end
      if (accept) begin
        fill_cnt  <= cnt_next;
        if (go_busy) begin
          busy       <= 1'b1;
          rem_shifts <= len_m1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_rd   <= rd_ok ? rd_sel : '0;
      out_cnt  <= 7'(cnt_next);
      out_st   <= st;
      busy_tgt <= ix;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_st, out_cnt, out_rd};

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    fill_cnt <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !s_tready)
    else $error("command taken during range shift");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted command gave no result");

  a_busy_ends: assert property (@(posedge clk) disable iff (rst)
    (busy && rem_shifts == TW'(1)) |=> !busy)
    else $error("range shift did not finish");

endmodule

`default_nettype wire

// File: dv/tb_shifting_array_engine_top.sv
// Self-checking testbench for the shifting array engine: directed and random list commands.
`timescale 1ns / 1ps

module tb_shifting_array_engine_top;
  import sae_pkg::*;

  localparam int DEPTH = 64;
  localparam logic [2:0] CMD_UNUSED = 3'd7;

  typedef struct packed {
    word_t      read_value;
    logic [6:0] count;
    logic [1:0] status;
  } list_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;   // command[2:0], index[8:3], end_index[14:9], value[46:15]
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;   // read_value[31:0], count[38:32], status[40:39]

  // shadow copy of the list contents
  word_t list_words [0:DEPTH-1];
  int    list_len;

  list_result_t pending_results[$];
  int           errors;
  int           send_idle_pct;
  int           recv_idle_pct;

  shifting_array_engine_top #(.CAPACITY(DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Applies one command to the shadow list and returns the result it should give.
  function automatic list_result_t apply_command(logic [2:0] cmd, logic [5:0] idx,
                                                 logic [5:0] eidx, word_t val);
    list_result_t res;
    int           i;
    int           span;
    res.read_value = '0;
    res.status     = ST_OK;
    case (cmd)
      CMD_APPEND: begin
        if (list_len >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          list_words[list_len] = val;
          list_len++;
        end
      end
      CMD_INSERT: begin
        if (list_len >= DEPTH) begin
          res.status = ST_FULL;
        end else if (int'(idx) > list_len) begin
          res.status = ST_RANGE;
        end else begin
          for (i = list_len; i > int'(idx); i--) list_words[i] = list_words[i-1];
          list_words[idx] = val;
          list_len++;
        end
      end
      CMD_SET: begin
        if (int'(idx) >= list_len) res.status = ST_RANGE;
        else list_words[idx] = val;
      end
      CMD_READ: begin
        if (int'(idx) >= list_len) res.status = ST_RANGE;
        else res.read_value = list_words[idx];
      end
      CMD_REMOVE: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else if (int'(idx) >= list_len) begin
          res.status = ST_RANGE;
        end else begin
          for (i = idx; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
        end
      end
      CMD_REM_RANGE: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else if (idx > eidx || int'(eidx) >= list_len) begin
          res.status = ST_RANGE;
        end else begin
          span = int'(eidx) - int'(idx) + 1;
          for (i = idx; i + span < list_len; i++) list_words[i] = list_words[i+span];
          list_len -= span;
        end
      end
      CMD_REM_LAST: begin
        if (list_len == 0) res.status = ST_EMPTY;
        else list_len--;
      end
      default: ;
    endcase
    res.count = list_len[6:0];
    return res;
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    list_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, m_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        compare_field("read_value", want.read_value, m_tdata[31:0]);
        compare_field("count", 32'(want.count), 32'(m_tdata[38:32]));
        compare_field("status", 32'(want.status), 32'(m_tdata[40:39]));
      end
    end
  end

  initial begin
    m_tready = 1'b0;
    forever @(negedge clk) m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic send_command(input logic [2:0] cmd, input logic [5:0] idx,
                              input logic [5:0] eidx, input word_t val);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, val, eidx, idx, cmd};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(apply_command(cmd, idx, eidx, val));
  endtask

  task automatic drain_pending();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_list();
    send_command(CMD_REMOVE, 6'd0, 6'd0, 32'sd0);
    send_command(CMD_REM_LAST, 6'd0, 6'd0, 32'sd0);
    send_command(CMD_REM_RANGE, 6'd0, 6'd0, 32'sd0);
    send_command(CMD_READ, 6'd0, 6'd0, 32'sd0);
    send_command(CMD_SET, 6'd0, 6'd0, 32'sd5);
    send_command(CMD_INSERT, 6'd1, 6'd0, 32'sd9);
    // insert at the fill count behaves as append
    send_command(CMD_INSERT, 6'd0, 6'd0, 32'h7fff_ffff);
  endtask

  task automatic test_edits();
    send_command(CMD_APPEND, 6'd0, 6'd0, 32'h8000_0000);
    send_command(CMD_APPEND, 6'd0, 6'd0, 32'hffff_ffff);
    send_command(CMD_APPEND, 6'd0, 6'd0, 32'h0000_0000);
    send_command(CMD_INSERT, 6'd4, 6'd0, 32'h5555_5555);
    send_command(CMD_INSERT, 6'd1, 6'd0, 32'haaaa_aaaa);
    send_command(CMD_INSERT, 6'd63, 6'd0, 32'h1234_5678);
    send_command(CMD_SET, 6'd5, 6'd0, 32'hffff_ffff);
    send_command(CMD_SET, 6'd6, 6'd0, 32'h1);
    send_command(CMD_READ, 6'd1, 6'd0, 32'sd0);
    send_command(CMD_READ, 6'd5, 6'd0, 32'sd0);
    send_command(CMD_READ, 6'd63, 6'd63, 32'sd0);
    send_command(CMD_REMOVE, 6'd0, 6'd0, 32'sd0);
    send_command(CMD_REMOVE, 6'd9, 6'd0, 32'sd0);
    send_command(CMD_REM_RANGE, 6'd3, 6'd1, 32'sd0);
    send_command(CMD_REM_RANGE, 6'd1, 6'd63, 32'sd0);
    send_command(CMD_REM_RANGE, 6'd1, 6'd2, 32'sd0);
    send_command(CMD_UNUSED, 6'd63, 6'd63, 32'hffff_ffff);
    send_command(CMD_REM_LAST, 6'd0, 6'd0, 32'sd0);
    send_command(CMD_READ, 6'd0, 6'd0, 32'sd0);
  endtask

  task automatic test_fill_to_capacity();
    while (list_len < DEPTH) send_command(CMD_APPEND, 6'd0, 6'd0, word_t'($urandom));
    send_command(CMD_APPEND, 6'd0, 6'd0, 32'sd1);
    // full is reported before any index check
    send_command(CMD_INSERT, 6'd63, 6'd0, 32'sd2);
    send_command(CMD_INSERT, 6'd0, 6'd0, 32'sd3);
    send_command(CMD_READ, 6'd63, 6'd0, 32'sd0);
    send_command(CMD_SET, 6'd63, 6'd0, 32'h7fff_ffff);
    send_command(CMD_REMOVE, 6'd63, 6'd0, 32'sd0);
    send_command(CMD_INSERT, 6'd63, 6'd0, 32'h8000_0000);
    send_command(CMD_READ, 6'd63, 6'd0, 32'sd0);
    send_command(CMD_REM_RANGE, 6'd0, 6'd63, 32'sd0);
    send_command(CMD_REM_RANGE, 6'd0, 6'd63, 32'sd0);
  endtask

  // Mostly legal commands with the list kept busy between empty and full.
  task automatic test_random_traffic(input int n_cmds, input int s_idle, input int r_idle);
    int         k;
    int         grow_pct;
    int         pick;
    logic [2:0] cmd;
    logic [5:0] idx;
    logic [5:0] eidx;
    int         last_ok;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (k = 0; k < n_cmds; k++) begin
      grow_pct = (list_len < 20) ? 60 : (list_len > 56) ? 25 : 42;
      pick = $urandom_range(0, 99);
      if (pick < grow_pct) begin
        cmd = ($urandom_range(0, 1) == 0) ? CMD_APPEND : CMD_INSERT;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 25)      cmd = CMD_SET;
        else if (pick < 55) cmd = CMD_READ;
        else if (pick < 75) cmd = CMD_REMOVE;
        else if (pick < 85) cmd = CMD_REM_RANGE;
        else if (pick < 97) cmd = CMD_REM_LAST;
        else                cmd = CMD_UNUSED;
      end
      last_ok = (cmd == CMD_INSERT) ? list_len : list_len - 1;
      if (last_ok < 0 || $urandom_range(0, 99) < 15) idx = 6'($urandom_range(0, 63));
      else idx = 6'($urandom_range(0, last_ok));
      if (cmd != CMD_REM_RANGE || list_len == 0 || $urandom_range(0, 99) < 15)
        eidx = 6'($urandom_range(0, 63));
      else if (int'(idx) > list_len - 1)
        eidx = 6'($urandom_range(0, list_len - 1));
      else if ($urandom_range(0, 9) == 0)
        eidx = 6'($urandom_range(idx, list_len - 1));
      else
        eidx = 6'((int'(idx) + int'($urandom_range(0, 3)) > list_len - 1) ?
                  list_len - 1 : int'(idx) + int'($urandom_range(0, 3)));
      send_command(cmd, idx, eidx, word_t'($urandom));
    end
  endtask

  initial begin
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    errors        = 0;
    list_len      = 0;
    send_idle_pct = 16;
    recv_idle_pct = 84;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_list();
    test_edits();
    test_fill_to_capacity();
    drain_pending();
    test_random_traffic(150, 16, 84);
    test_random_traffic(150, 84, 16);
    drain_pending();
    test_random_traffic(150, 0, 0);
    drain_pending();
    // range removals shift one entry per cycle; leave room for a stray result
    repeat (100) @(posedge clk);

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
